FILE: rtl/irbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irbs_pkg
// Shared types and constants of the intra refresh band scheduler.
// ----------------------------------------------------------------------------
package irbs_pkg;

    localparam int unsigned BAND_SPAN_PIXELS     = 128;
    localparam int unsigned DEFAULT_BLOCK_PIXELS = 64;
    localparam int unsigned DIV_W                = 24;
    localparam int unsigned DEN_W                = 12;

    // register map, word index
    localparam logic [2:0] REG_ROWS     = 3'd0;
    localparam logic [2:0] REG_COLS     = 3'd1;
    localparam logic [2:0] REG_PERIOD   = 3'd2;
    localparam logic [2:0] REG_DURATION = 3'd3;
    localparam logic [2:0] REG_BLOCK    = 3'd4;
    localparam logic [2:0] REG_BAND_H   = 3'd5;
    localparam logic [2:0] REG_BAND_W   = 3'd6;

    typedef enum logic [1:0] {
        REQ_STEP    = 2'd0,
        REQ_REALIGN = 2'd1,
        REQ_RESTART = 2'd2
    } t_req;

    typedef enum logic [3:0] {
        OP_NONE, OP_BH, OP_CC, OP_RR, OP_RF, OP_IDX, OP_RC, OP_SR, OP_SC, OP_REC
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BH, ST_CC, ST_RR, ST_RF, ST_IDX, ST_RC, ST_SR, ST_SC, ST_REC, ST_FIN
    } t_state;

    typedef struct packed {
        logic [7:0]  picture_rows;
        logic [7:0]  picture_cols;
        logic [11:0] refresh_period;
        logic [11:0] sweep_duration;
        logic [7:0]  block_pixels;
        logic [7:0]  band_height;
        logic [7:0]  band_width;
    } t_cfg;

    typedef struct packed {
        logic idle;
        logic load;
        logic start;
        logic capture;
        logic finish;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic div_done;
        logic bh_given;
        logic rr_over;
        logic step;
        logic due;
        logic idx_zero;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/irbs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irbs_div
// Restoring divider, one quotient bit per cycle, selectable dividend width.
// ----------------------------------------------------------------------------
module irbs_div
    import irbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DIV_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]   i_den,
    input  wire logic [4:0]         i_nbits,
    output logic [DIV_W-1:0]        o_quo,
    output logic [DEN_W-1:0]        o_rem,
    output logic                    o_done
);
    logic [DIV_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [4:0]       r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {r_rem[DEN_W-1:0], r_quo[DIV_W-1]};
    assign fits  = trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num << (5'(DIV_W) - i_nbits);
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial - {1'b0, i_den} : trial;
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem[DEN_W-1:0];
    assign o_done = r_done;
endmodule
`default_nettype wire

FILE: rtl/irbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irbs_ctrl
// Sequencer: resolve geometry, place the region, hand over the word.
// ----------------------------------------------------------------------------
module irbs_ctrl
    import irbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;
    logic   r_issued, n_issued;
    logic   is_div, skip;

    always_comb begin
        is_div = 1'b1;
        skip   = 1'b0;
        unique case (r_state)
            ST_BH:   skip = i_sts.bh_given;
            ST_RF:   skip = !i_sts.rr_over;
            ST_RC:   skip = !i_sts.due;
            ST_REC:  skip = !i_sts.idx_zero;
            ST_CC, ST_RR, ST_IDX, ST_SR, ST_SC: skip = 1'b0;
            default: is_div = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        if (is_div) begin
            if (skip || (r_issued && i_sts.div_done)) begin
                n_issued = 1'b0;
                unique case (r_state)
                    ST_BH:   n_state = ST_CC;
                    ST_CC:   n_state = ST_RR;
                    ST_RR:   n_state = ST_RF;
                    ST_RF:   n_state = i_sts.step ? ST_IDX : ST_FIN;
                    ST_IDX:  n_state = ST_RC;
                    ST_RC:   n_state = i_sts.due ? ST_SR : ST_FIN;
                    ST_SR:   n_state = ST_SC;
                    ST_SC:   n_state = ST_REC;
                    default: n_state = ST_FIN;
                endcase
            end else if (!r_issued) begin
                n_issued = 1'b1;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: if (i_sts.in_valid) n_state = ST_BH;
                ST_FIN:  if (i_sts.out_free) n_state = ST_IDLE;
                default: n_state = ST_IDLE;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = OP_NONE;
        o_cmd.idle    = (r_state == ST_IDLE);
        o_cmd.load    = (r_state == ST_IDLE) && i_sts.in_valid;
        o_cmd.finish  = (r_state == ST_FIN) && i_sts.out_free;
        o_cmd.start   = is_div && !skip && !r_issued;
        o_cmd.capture = is_div && (skip || (r_issued && i_sts.div_done));
        unique case (r_state)
            ST_BH:   o_cmd.op = OP_BH;
            ST_CC:   o_cmd.op = OP_CC;
            ST_RR:   o_cmd.op = OP_RR;
            ST_RF:   o_cmd.op = OP_RF;
            ST_IDX:  o_cmd.op = OP_IDX;
            ST_RC:   o_cmd.op = OP_RC;
            ST_SR:   o_cmd.op = OP_SR;
            ST_SC:   o_cmd.op = OP_SC;
            ST_REC:  o_cmd.op = OP_REC;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/irbs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irbs_dp
// Datapath: resolved geometry, sweep state, shared divider, result register.
// ----------------------------------------------------------------------------
module irbs_dp
    import irbs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        i_in_valid,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [8:0]  i_forced_top,
    input  wire logic [7:0]  i_forced_count,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_band_apply,
    output logic             o_band_forced,
    output logic [7:0]       o_band_top,
    output logic [7:0]       o_band_bottom,
    output logic [7:0]       o_band_left,
    output logic [7:0]       o_band_right,
    output logic [11:0]      o_recov_pics
);
    function automatic logic [15:0] split(input logic [7:0] base, input logic [7:0] rem,
                                          input logic [7:0] idx);
        logic [15:0] prod;
        logic [8:0]  first, last;
        logic        low;
        low   = idx < rem;
        prod  = idx * base;
        first = prod[8:0] + {1'b0, (low ? idx : rem)};
        last  = first + {1'b0, base} + {8'd0, low} - 9'd1;
        return {last[7:0], first[7:0]};
    endfunction

    // resolved configuration
    logic [7:0]  rows, cols, bp, bw;
    logic [11:0] period, dur;

    assign rows   = (i_cfg.picture_rows == '0) ? 8'd1 : i_cfg.picture_rows;
    assign cols   = (i_cfg.picture_cols == '0) ? 8'd1 : i_cfg.picture_cols;
    assign period = (i_cfg.refresh_period == '0) ? 12'd1 : i_cfg.refresh_period;
    assign dur    = (i_cfg.sweep_duration == '0 || i_cfg.sweep_duration > period)
                    ? period : i_cfg.sweep_duration;
    assign bp     = (i_cfg.block_pixels == '0) ? 8'(DEFAULT_BLOCK_PIXELS)
                    : i_cfg.block_pixels;
    assign bw     = (i_cfg.band_width == '0 || i_cfg.band_width > cols) ? cols
                    : i_cfg.band_width;

    logic [1:0]        r_req;
    logic [8:0]        r_ftop;
    logic [7:0]        r_fcnt;
    logic [7:0]        r_bh, r_cc, r_rr, r_rs, r_cs;
    logic [7:0]        r_rtop, r_rbot, r_cleft, r_cright;
    logic [11:0]       r_total, r_idx, r_rec, r_sp;
    logic signed [12:0] r_last;
    logic              r_ovalid;

    logic [DIV_W-1:0] div_num, div_q;
    logic [DEN_W-1:0] div_den, div_r;
    logic [4:0]       div_n;
    logic             div_done;
    logic [24:0]      idx_prod;
    logic [23:0]      rec_prod;
    logic [15:0]      rr_cc, rr_new_prod;
    logic [7:0]       bh_sel, rr_new;
    logic [15:0]      row_span, col_span;
    logic             due;

    assign idx_prod = ({1'b0, r_sp} + 13'd1) * r_total - 25'd1;
    assign rec_prod = (r_total - 12'd1) * dur;
    assign rr_cc    = r_rr * r_cc;

    always_comb begin
        div_num = '0;
        div_den = 12'd1;
        div_n   = 5'd8;
        case (i_cmd.op)
            OP_BH:  begin
                div_num = 24'(BAND_SPAN_PIXELS);
                div_den = {4'd0, bp};
            end
            OP_CC:  begin
                div_num = {15'd0, {1'b0, cols} + {1'b0, bw} - 9'd1};
                div_den = {4'd0, bw};
                div_n   = 5'd12;
            end
            OP_RR:  begin
                div_num = {15'd0, {1'b0, rows} + {1'b0, r_bh} - 9'd1};
                div_den = {4'd0, r_bh};
                div_n   = 5'd12;
            end
            OP_RF:  begin
                div_num = {12'd0, dur};
                div_den = {4'd0, r_cc};
                div_n   = 5'd12;
            end
            OP_IDX: begin
                div_num = idx_prod[23:0];
                div_den = dur;
                div_n   = 5'd24;
            end
            OP_RC:  begin
                div_num = {12'd0, r_idx};
                div_den = {4'd0, r_cc};
                div_n   = 5'd12;
            end
            OP_SR:  begin
                div_num = {16'd0, rows};
                div_den = {4'd0, r_rr};
            end
            OP_SC:  begin
                div_num = {16'd0, cols};
                div_den = {4'd0, r_cc};
            end
            OP_REC: begin
                div_num = rec_prod;
                div_den = r_total;
                div_n   = 5'd24;
            end
            default: div_n = 5'd8;
        endcase
    end

    irbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_nbits (div_n),
        .o_quo   (div_q),
        .o_rem   (div_r),
        .o_done  (div_done)
    );

    always_comb begin
        bh_sel = (i_cfg.band_height != '0) ? i_cfg.band_height
                 : ((div_q[7:0] == '0) ? 8'd1 : div_q[7:0]);
        if (bh_sel > rows) bh_sel = rows;
        rr_new = o_sts.rr_over ? ((div_q[7:0] == '0) ? 8'd1 : div_q[7:0]) : r_rr;
    end
    assign rr_new_prod = rr_new * r_cc;
    assign row_span    = split(div_q[7:0], div_r[7:0], r_rs);
    assign col_span    = split(div_q[7:0], div_r[7:0], r_cs);

    // capture the request on load and each division result into its destination
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_ftop <= i_forced_top;
            r_fcnt <= i_forced_count;
        end
        if (i_cmd.capture) begin
            case (i_cmd.op)
                OP_BH:  r_bh <= bh_sel;
                OP_CC:  r_cc <= (div_q[11:0] > dur) ? dur[7:0] : div_q[7:0];
                OP_RR:  r_rr <= div_q[7:0];
                OP_RF:  begin
                    r_rr    <= rr_new;
                    r_total <= rr_new_prod[11:0];
                end
                OP_IDX: r_idx <= (div_q > {12'd0, r_total - 12'd1}) ? r_total - 12'd1
                                 : div_q[11:0];
                OP_RC:  begin
                    r_rs <= div_q[7:0];
                    r_cs <= div_r[7:0];
                end
                OP_SR:  begin
                    r_rtop <= row_span[7:0];
                    r_rbot <= row_span[15:8];
                end
                OP_SC:  begin
                    r_cleft  <= col_span[7:0];
                    r_cright <= col_span[15:8];
                end
                OP_REC: r_rec <= o_sts.idx_zero ? div_q[11:0] : 12'd0;
                default: r_rec <= r_rec;
            endcase
        end
    end

    assign due = $signed({1'b0, r_idx}) > r_last;

    // result of the finished item
    logic              f_apply, f_forced;
    logic [7:0]        f_top, f_bottom, f_left, f_right, last_row, last_col;
    logic [11:0]       f_rec;
    logic signed [10:0] ft, fb, ftc, fbc;

    assign last_row = rows - 8'd1;
    assign last_col = cols - 8'd1;

    always_comb begin
        ft  = 11'(signed'(r_ftop));
        fb  = ft + $signed({3'd0, r_fcnt}) - 11'sd1;
        ftc = (ft < 0) ? 11'sd0 : ft;
        fbc = (fb > $signed({3'd0, last_row})) ? $signed({3'd0, last_row}) : fb;
        f_apply  = 1'b0;
        f_forced = 1'b0;
        f_top    = '0;
        f_bottom = '0;
        f_left   = '0;
        f_right  = last_col;
        f_rec    = '0;
        if (r_req == REQ_STEP) begin
            if (r_fcnt != '0 && !due) begin
                if (fbc >= ftc) begin
                    f_apply  = 1'b1;
                    f_forced = 1'b1;
                    f_top    = ftc[7:0];
                    f_bottom = fbc[7:0];
                end
            end else if (due) begin
                f_apply  = 1'b1;
                f_top    = r_rtop;
                f_bottom = (r_rbot > last_row) ? last_row : r_rbot;
                f_left   = r_cleft;
                f_right  = (r_cright > last_col) ? last_col : r_cright;
                f_rec    = r_rec;
            end
        end
    end

    logic [11:0] sp_inc;
    assign sp_inc = r_sp + 12'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_last   <= -13'sd1;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
                case (r_req)
                    REQ_STEP: begin
                        if (sp_inc >= period) begin
                            r_sp   <= '0;
                            r_last <= -13'sd1;
                        end else begin
                            r_sp <= sp_inc;
                            if (due && !(r_fcnt != '0 && !due)) r_last <= {1'b0, r_idx};
                        end
                    end
                    REQ_REALIGN: begin
                        r_sp   <= '0;
                        r_last <= $signed({1'b0, r_total - 12'd1});
                    end
                    REQ_RESTART: begin
                        r_sp   <= '0;
                        r_last <= -13'sd1;
                    end
                    default: r_sp <= r_sp;
                endcase
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_band_apply     <= f_apply;
            o_band_forced    <= f_forced;
            o_band_top       <= f_top;
            o_band_bottom    <= f_bottom;
            o_band_left      <= f_left;
            o_band_right     <= f_right;
            o_recov_pics     <= f_rec;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_sts.in_valid = i_in_valid;
    assign o_sts.div_done = div_done;
    assign o_sts.bh_given = (i_cfg.band_height != '0);
    assign o_sts.rr_over  = rr_cc > {4'd0, dur};
    assign o_sts.step     = (r_req == REQ_STEP);
    assign o_sts.due      = due;
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.out_free = !r_ovalid || i_out_ready;
endmodule
`default_nettype wire

FILE: rtl/intra_refresh_band_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// intra_refresh_band_scheduler
// Picks the intra refreshed rectangle of block rows and columns per picture.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | word
//  s_axis    | in        | tvalid / tready           | one picture request
//  m_axis    | out       | tvalid / tready           | one refresh decision
//  apb       | in        | psel, penable, pwrite     | geometry registers
//
//  Each word runs up to nine divisions through one shared restoring divider
//  (one quotient bit a cycle), of 8, 12 or 24 steps each; some divisions are
//  skipped when the state makes them unneeded, and a stalled output can hold
//  the word.
//  The geometry is resolved again from the registers for every word.
//  Reset (synchronous, active low) clears the sweep position and empties the
//  output register. A new word is taken as soon as the sequencer is idle, even
//  while the previous decision waits in the output register; a stalled output
//  holds the sequencer in its final step only when that register is occupied.
// ----------------------------------------------------------------------------
module intra_refresh_band_scheduler
    import irbs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // forced_top[8:0], forced_count[16:9]
    input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // band_top[7:0], band_bottom[15:8],
                                            // band_left[23:16], band_right[31:24],
                                            // recov_pics[43:32]
    output logic [1:0]       m_axis_tuser,  // band_apply[0], band_forced[1]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register file; writes must arrive only while idle, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.picture_rows   <= 8'd1;
            r_cfg.picture_cols   <= 8'd1;
            r_cfg.refresh_period <= 12'd1;
            r_cfg.sweep_duration <= 12'd0;
            r_cfg.block_pixels   <= 8'(DEFAULT_BLOCK_PIXELS);
            r_cfg.band_height    <= 8'd0;
            r_cfg.band_width     <= 8'd0;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_ROWS:     r_cfg.picture_rows   <= pwdata[7:0];
                REG_COLS:     r_cfg.picture_cols   <= pwdata[7:0];
                REG_PERIOD:   r_cfg.refresh_period <= pwdata[11:0];
                REG_DURATION: r_cfg.sweep_duration <= pwdata[11:0];
                REG_BLOCK:    r_cfg.block_pixels   <= pwdata[7:0];
                REG_BAND_H:   r_cfg.band_height    <= pwdata[7:0];
                REG_BAND_W:   r_cfg.band_width     <= pwdata[7:0];
                default:      r_cfg.band_width     <= r_cfg.band_width;
            endcase
        end
    end

    // read back the raw register contents
    always_comb begin
        unique case (paddr[4:2])
            REG_ROWS:     prdata = {24'd0, r_cfg.picture_rows};
            REG_COLS:     prdata = {24'd0, r_cfg.picture_cols};
            REG_PERIOD:   prdata = {20'd0, r_cfg.refresh_period};
            REG_DURATION: prdata = {20'd0, r_cfg.sweep_duration};
            REG_BLOCK:    prdata = {24'd0, r_cfg.block_pixels};
            REG_BAND_H:   prdata = {24'd0, r_cfg.band_height};
            REG_BAND_W:   prdata = {24'd0, r_cfg.band_width};
            default:      prdata = '0;
        endcase
    end

    assign s_axis_tready = cmd.idle;

    irbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    irbs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_in_valid       (s_axis_tvalid),
        .i_req_type       (s_axis_tuser),
        .i_forced_top     (s_axis_tdata[8:0]),
        .i_forced_count   (s_axis_tdata[16:9]),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_band_apply     (m_axis_tuser[0]),
        .o_band_forced    (m_axis_tuser[1]),
        .o_band_top       (m_axis_tdata[7:0]),
        .o_band_bottom    (m_axis_tdata[15:8]),
        .o_band_left      (m_axis_tdata[23:16]),
        .o_band_right     (m_axis_tdata[31:24]),
        .o_recov_pics     (m_axis_tdata[43:32])
    );

    assign m_axis_tdata[47:44] = 4'd0;

    // leave idle right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sequencer still idle after accepting a word");

    // a finished decision always lands in the output register
    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("finished decision not presented");

    // a forced region is always an applied one
    a_forced_applies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("forced flag without apply");

    // no region means no rows and a zero left column
    a_idle_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[23:16] == 8'd0)
        else $error("idle decision carries a region");
endmodule
`default_nettype wire
